[rtl/ptlr_pkg.sv]
// Shared types and constants for the peer table router.
package ptlr_pkg;

  localparam logic [2:0] CMD_ANNOUNCE  = 3'd0;
  localparam logic [2:0] CMD_HEARTBEAT = 3'd1;
  localparam logic [2:0] CMD_SPAWN     = 3'd2;
  localparam logic [2:0] CMD_STATUS    = 3'd3;
  localparam logic [2:0] CMD_TICK      = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_REMOTE  = 3'd2;
  localparam logic [2:0] ST_LOCAL   = 3'd3;
  localparam logic [2:0] ST_NOPEER  = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_SWEEP   = 1'b1;

  localparam logic [7:0] TIMEOUT_RESET = 8'd30;
  localparam logic [7:0] SWEEP_RESET   = 8'd10;

  localparam int SUM_W = 19;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

[rtl/ptlr_entry_mem.sv]
// Peer entry store: one synchronous memory, one read port, one write port.
module ptlr_entry_mem #(
  parameter int AW = 3,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/peer_table_least_loaded_router_core.sv]
// Peer table router: sequencer walking the entry memory one entry a cycle.
//
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/ready | command, peer_id, slots, want_gpu, strict_spawn
//  out     | output    | out_valid/ready| status_code ... dropped_mask
//  cfg     | input     | cfg_valid/ready| cfg_index, cfg_data
//
// A beat is taken in the idle state; its result is offered after S_SCAN reads every
// entry through the single read port, S_WAIT covers the read latency, S_WRITE does
// the one write-back and S_DONE registers the result.
// Online flags live in flip-flops and reset to zero; entry payload does not.
// Input stays closed while a result waits, so a new item is taken only once the last
// result is accepted; out_ready low holds it back. Config is taken only when idle.
module peer_table_least_loaded_router_core #(
  parameter int PEER_ENTRIES = 8,
  parameter int SLOT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [63:0] peer_id,
  input  logic [15:0] wrk_total,
  input  logic [15:0] wrk_avail,
  input  logic [15:0] gpu_slots,
  input  logic [15:0] gpu_avail,
  input  logic        want_gpu,
  input  logic        strict_spawn,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status_code,
  output logic [63:0] chosen_id,
  output logic [2:0]  chosen_index,
  output logic [3:0]  online_count,
  output logic [18:0] sum_worker_total,
  output logic [18:0] sum_worker_free,
  output logic [18:0] sum_gpu_total,
  output logic [18:0] sum_gpu_free,
  output logic [31:0] local_spawn_count,
  output logic [31:0] remote_spawn_count,
  output logic [7:0]  dropped_mask,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
  localparam int CW = $clog2(PEER_ENTRIES + 1);
  localparam int DW = 64 + 4 * SLOT_BITS + 32;
  localparam int MW = (PEER_ENTRIES < 8) ? PEER_ENTRIES : 8;
  localparam int SUM_W_L = ptlr_pkg::SUM_W;

  ptlr_pkg::state_t state, state_next;

  logic [7:0]  timeout_ticks, sweep_interval, sweep_countdown;
  logic [31:0] tick_count, local_spawns, remote_spawns, failed_spawns;
  logic [PEER_ENTRIES-1:0] online;

  // latched item
  logic [2:0]  cmd;
  logic [63:0] id;
  logic [SLOT_BITS-1:0] wt_in, wf_in, gt_in, gf_in;
  logic gpu, strict, sweep;

  // scan
  logic [CW-1:0] ridx;
  logic [AW-1:0] cidx;
  logic          cvalid;
  logic [DW-1:0] rdata;
  logic [63:0]          r_id;
  logic [SLOT_BITS-1:0] r_wt, r_wf, r_gt, r_gf;
  logic [31:0]          r_seen;

  logic           hit, found_free, best_ok;
  logic [AW-1:0]  hit_idx, free_idx, best_idx;
  logic [SLOT_BITS-1:0] best_cnt;
  logic [63:0]    best_id;
  logic [DW-1:0]  best_data;
  logic [3:0]     n_acc;
  logic [SUM_W_L-1:0] s_wt, s_wf, s_gt, s_gf;
  logic [PEER_ENTRIES-1:0] drop;

  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;

  logic in_acc, out_acc;
  logic [SLOT_BITS-1:0] f_rank;
  logic [31:0] quiet;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cfg_ready = (state == ptlr_pkg::S_IDLE);
  assign in_ready  = (state == ptlr_pkg::S_IDLE) && !out_valid;

  assign {r_id, r_wt, r_wf, r_gt, r_gf, r_seen} = rdata;
  assign f_rank = gpu ? r_gf : r_wf;
  assign quiet  = (tick_count + 32'd1) - r_seen;

  ptlr_entry_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .raddr (ridx[AW-1:0]),
    .rdata (rdata),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptlr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ptlr_pkg::S_IDLE:  if (in_acc) state_next = ptlr_pkg::S_SCAN;
      ptlr_pkg::S_SCAN:  if (ridx == CW'(PEER_ENTRIES - 1)) state_next = ptlr_pkg::S_WAIT;
      ptlr_pkg::S_WAIT:  state_next = ptlr_pkg::S_WRITE;
      ptlr_pkg::S_WRITE: state_next = ptlr_pkg::S_DONE;
      ptlr_pkg::S_DONE:  state_next = ptlr_pkg::S_IDLE;
      default:           state_next = ptlr_pkg::S_IDLE;
    endcase
  end

  // write-back selection
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (state == ptlr_pkg::S_WRITE) begin
      priority case (cmd)
        ptlr_pkg::CMD_ANNOUNCE: begin
          we    = hit || found_free;
          waddr = hit ? hit_idx : free_idx;
          wdata = {id, wt_in, wf_in, gt_in, gf_in, tick_count};
        end
        ptlr_pkg::CMD_HEARTBEAT: begin
          we    = hit;
          waddr = hit_idx;
          wdata = {best_data[DW-1:32], tick_count};
        end
        ptlr_pkg::CMD_SPAWN: begin
          we    = best_ok;
          waddr = best_idx;
          wdata = best_data;
          if (gpu) wdata[32 +: SLOT_BITS] = best_cnt - SLOT_BITS'(1);
          else     wdata[32 + 2*SLOT_BITS +: SLOT_BITS] = best_cnt - SLOT_BITS'(1);
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks   <= ptlr_pkg::TIMEOUT_RESET;
      sweep_interval  <= ptlr_pkg::SWEEP_RESET;
      sweep_countdown <= ptlr_pkg::SWEEP_RESET;
      tick_count      <= '0;
      local_spawns    <= '0;
      remote_spawns   <= '0;
      failed_spawns   <= '0;
      online          <= '0;
      out_valid       <= 1'b0;
      ridx            <= '0;
      cvalid          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ptlr_pkg::CFG_TIMEOUT: timeout_ticks  <= cfg_data;
          ptlr_pkg::CFG_SWEEP:   sweep_interval <= cfg_data;
        endcase
      end
      if (out_acc) out_valid <= 1'b0;
      cvalid <= (state == ptlr_pkg::S_SCAN);
      cidx   <= ridx[AW-1:0];
      unique case (state)
        ptlr_pkg::S_IDLE: begin
          ridx <= '0;
          if (in_acc) begin
            cmd    <= command;
            id     <= peer_id;
            wt_in  <= SLOT_BITS'(wrk_total);
            wf_in  <= SLOT_BITS'(wrk_avail);
            gt_in  <= SLOT_BITS'(gpu_slots);
            gf_in  <= SLOT_BITS'(gpu_avail);
            gpu    <= want_gpu;
            strict <= strict_spawn;
            sweep  <= (command == ptlr_pkg::CMD_TICK) && (sweep_countdown <= 8'd1);
            hit <= 1'b0; found_free <= 1'b0; best_ok <= 1'b0;
            hit_idx <= '0; free_idx <= '0; best_idx <= '0;
            best_cnt <= '0; best_id <= '0; best_data <= '0;
            n_acc <= '0; s_wt <= '0; s_wf <= '0; s_gt <= '0; s_gf <= '0;
            drop <= '0;
          end
        end
        ptlr_pkg::S_SCAN: ridx <= ridx + CW'(1);
        ptlr_pkg::S_WRITE: begin
          priority case (cmd)
            ptlr_pkg::CMD_ANNOUNCE:
              if (hit || found_free) online[hit ? hit_idx : free_idx] <= 1'b1;
            ptlr_pkg::CMD_SPAWN: begin
              if (best_ok) remote_spawns <= remote_spawns + 32'd1;
              else if (strict) failed_spawns <= failed_spawns + 32'd1;
              else local_spawns <= local_spawns + 32'd1;
            end
            ptlr_pkg::CMD_TICK: begin
              tick_count <= tick_count + 32'd1;
              if (sweep) begin
                sweep_countdown <= sweep_interval;
                online <= online & ~drop;
              end else begin
                sweep_countdown <= sweep_countdown - 8'd1;
              end
            end
            default: ;
          endcase
        end
        ptlr_pkg::S_DONE: begin
          out_valid          <= 1'b1;
          status_code        <= ptlr_pkg::ST_OK;
          chosen_id          <= '0;
          chosen_index       <= '0;
          online_count       <= '0;
          sum_worker_total   <= '0;
          sum_worker_free    <= '0;
          sum_gpu_total      <= '0;
          sum_gpu_free       <= '0;
          local_spawn_count  <= '0;
          remote_spawn_count <= '0;
          dropped_mask       <= '0;
          priority case (cmd)
            ptlr_pkg::CMD_ANNOUNCE: begin
              if (hit || found_free) chosen_index <= 3'(hit ? hit_idx : free_idx);
              else status_code <= ptlr_pkg::ST_FULL;
            end
            ptlr_pkg::CMD_HEARTBEAT: begin
              if (hit) chosen_index <= 3'(hit_idx);
              else status_code <= ptlr_pkg::ST_NOPEER;
            end
            ptlr_pkg::CMD_SPAWN: begin
              if (best_ok) begin
                status_code  <= ptlr_pkg::ST_REMOTE;
                chosen_id    <= best_id;
                chosen_index <= 3'(best_idx);
              end else begin
                status_code <= strict ? ptlr_pkg::ST_NOPEER : ptlr_pkg::ST_LOCAL;
              end
            end
            ptlr_pkg::CMD_STATUS: begin
              online_count       <= n_acc;
              sum_worker_total   <= s_wt;
              sum_worker_free    <= s_wf;
              sum_gpu_total      <= s_gt;
              sum_gpu_free       <= s_gf;
              local_spawn_count  <= local_spawns;
              remote_spawn_count <= remote_spawns;
            end
            ptlr_pkg::CMD_TICK: dropped_mask <= 8'(drop[MW-1:0]);
            default: status_code <= ptlr_pkg::ST_UNKNOWN;
          endcase
        end
        default: ;
      endcase
      // entry evaluation, in the cycle after its read address
      if (cvalid && online[cidx]) begin
        if (!hit && r_id == id) begin
          hit       <= 1'b1;
          hit_idx   <= cidx;
          if (cmd == ptlr_pkg::CMD_HEARTBEAT) best_data <= rdata;
        end
        if (f_rank > best_cnt) begin
          best_cnt  <= f_rank;
          best_ok   <= 1'b1;
          best_idx  <= cidx;
          best_id   <= r_id;
          if (cmd == ptlr_pkg::CMD_SPAWN) best_data <= rdata;
        end
        n_acc <= n_acc + 4'd1;
        s_wt  <= s_wt + SUM_W_L'(r_wt);
        s_wf  <= s_wf + SUM_W_L'(r_wf);
        s_gt  <= s_gt + SUM_W_L'(r_gt);
        s_gf  <= s_gf + SUM_W_L'(r_gf);
        if (sweep && quiet > 32'(timeout_ticks)) drop[cidx] <= 1'b1;
      end else if (cvalid && !found_free) begin
        found_free <= 1'b1;
        free_idx   <= cidx;
      end
    end
  end

endmodule

[rtl/ptlr_checker.sv]
// Port-level checks for the peer table router, bound to the top level.
module ptlr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       cfg_ready,
  input logic [2:0] status_code
);

  // one item in flight: no acceptance while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // a result never appears in the cycle after acceptance
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_code <= ptlr_pkg::ST_UNKNOWN)) else $error("bad status");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(status_code))
    else $error("result dropped");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> cfg_ready) else $error("cfg closed while idle");

endmodule

bind peer_table_least_loaded_router_core ptlr_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .cfg_ready   (cfg_ready),
  .status_code (status_code)
);
